>>> sv/ptmd_pkg.sv
// Types, register indexes and reset values shared by the tilt motor drive.
`default_nettype none
package ptmd_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 24;
    localparam int unsigned ANGLE_W    = 16;
    localparam int unsigned GAIN_W     = 24;
    localparam int unsigned INTEG_W    = 24;
    localparam int unsigned TILT_W     = 15;
    localparam int unsigned DUTY_W     = 16;
    localparam int unsigned ERR_W      = ANGLE_W + 1;
    localparam int unsigned SUM_W      = INTEG_W + 1;
    localparam int unsigned PROD_E_W   = GAIN_W + 1 + ERR_W;
    localparam int unsigned PROD_I_W   = GAIN_W + 1 + INTEG_W;
    localparam int unsigned DRIVE_W    = PROD_I_W + 1;
    localparam int unsigned FRAC_W     = 16;
    localparam int unsigned MAG_W      = DRIVE_W - FRAC_W;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_TARGET     = 3'd0;
    localparam t_cfg_idx REG_P_GAIN     = 3'd1;
    localparam t_cfg_idx REG_I_GAIN     = 3'd2;
    localparam t_cfg_idx REG_D_GAIN     = 3'd3;
    localparam t_cfg_idx REG_INTEG_MAX  = 3'd4;
    localparam t_cfg_idx REG_INTEG_MIN  = 3'd5;
    localparam t_cfg_idx REG_TILT_LIMIT = 3'd6;
    localparam t_cfg_idx REG_DUTY_LIMIT = 3'd7;

    localparam logic signed [ANGLE_W-1:0] RST_TARGET     = -16'sd2560;
    localparam logic [GAIN_W-1:0]         RST_P_GAIN     = 24'd76800;
    localparam logic [GAIN_W-1:0]         RST_I_GAIN     = 24'd13;
    localparam logic [GAIN_W-1:0]         RST_D_GAIN     = 24'd0;
    localparam logic signed [INTEG_W-1:0] RST_INTEG_MAX  = 24'sd256000;
    localparam logic signed [INTEG_W-1:0] RST_INTEG_MIN  = -24'sd256000;
    localparam logic [TILT_W-1:0]         RST_TILT_LIMIT = 15'd6400;
    localparam logic [DUTY_W-1:0]         RST_DUTY_LIMIT = 16'd1000;

endpackage
`default_nettype wire

>>> sv/pid_tilt_motor_drive.sv
// Balance PID drive: clamped integrator, derivative on measurement, duty output.
// Each accepted sample passes the stage 1, 2 and 3 registers, then the output.
// Throughput: one transaction per cycle; the integrator add/clamp is registered
// at accept, the three gain multiplies and the drive sum are pipelined.
// The pipeline stalls only when the output register holds an untaken result.
// Reset (synchronous, active low): config registers take their package values,
// integrator, previous angle, held duty and direction clear, pipeline empties.
`default_nettype none
module pid_tilt_motor_drive (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // configuration write port
    input  wire logic                                i_cfg_we,
    input  wire logic [ptmd_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [ptmd_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // tilt sample channel
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic signed [ptmd_pkg::ANGLE_W-1:0] i_tilt_angle,
    // drive command channel
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic                                     o_motor_enable,
    output logic                                     o_reverse,
    output logic [ptmd_pkg::DUTY_W-1:0]              o_duty
);

    localparam int unsigned ANGLE_W  = ptmd_pkg::ANGLE_W;
    localparam int unsigned GAIN_W   = ptmd_pkg::GAIN_W;
    localparam int unsigned INTEG_W  = ptmd_pkg::INTEG_W;
    localparam int unsigned TILT_W   = ptmd_pkg::TILT_W;
    localparam int unsigned DUTY_W   = ptmd_pkg::DUTY_W;
    localparam int unsigned ERR_W    = ptmd_pkg::ERR_W;
    localparam int unsigned SUM_W    = ptmd_pkg::SUM_W;
    localparam int unsigned PROD_E_W = ptmd_pkg::PROD_E_W;
    localparam int unsigned PROD_I_W = ptmd_pkg::PROD_I_W;
    localparam int unsigned DRIVE_W  = ptmd_pkg::DRIVE_W;
    localparam int unsigned FRAC_W   = ptmd_pkg::FRAC_W;
    localparam int unsigned MAG_W    = ptmd_pkg::MAG_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [ANGLE_W-1:0] r_target;
    logic [GAIN_W-1:0]         r_p_gain;
    logic [GAIN_W-1:0]         r_i_gain;
    logic [GAIN_W-1:0]         r_d_gain;
    logic signed [INTEG_W-1:0] r_integ_max;
    logic signed [INTEG_W-1:0] r_integ_min;
    logic [TILT_W-1:0]         r_tilt_limit;
    logic [DUTY_W-1:0]         r_duty_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target     <= ptmd_pkg::RST_TARGET;
            r_p_gain     <= ptmd_pkg::RST_P_GAIN;
            r_i_gain     <= ptmd_pkg::RST_I_GAIN;
            r_d_gain     <= ptmd_pkg::RST_D_GAIN;
            r_integ_max  <= ptmd_pkg::RST_INTEG_MAX;
            r_integ_min  <= ptmd_pkg::RST_INTEG_MIN;
            r_tilt_limit <= ptmd_pkg::RST_TILT_LIMIT;
            r_duty_limit <= ptmd_pkg::RST_DUTY_LIMIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ptmd_pkg::REG_TARGET:     r_target     <= i_cfg_data[ANGLE_W-1:0];
                ptmd_pkg::REG_P_GAIN:     r_p_gain     <= i_cfg_data[GAIN_W-1:0];
                ptmd_pkg::REG_I_GAIN:     r_i_gain     <= i_cfg_data[GAIN_W-1:0];
                ptmd_pkg::REG_D_GAIN:     r_d_gain     <= i_cfg_data[GAIN_W-1:0];
                ptmd_pkg::REG_INTEG_MAX:  r_integ_max  <= i_cfg_data[INTEG_W-1:0];
                ptmd_pkg::REG_INTEG_MIN:  r_integ_min  <= i_cfg_data[INTEG_W-1:0];
                ptmd_pkg::REG_TILT_LIMIT: r_tilt_limit <= i_cfg_data[TILT_W-1:0];
                ptmd_pkg::REG_DUTY_LIMIT: r_duty_limit <= i_cfg_data[DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow: every stage moves together whenever the output
    // register is empty or is being taken this cycle. Hold off the tilt
    // channel while reset is applied.
    // ------------------------------------------------------------------
    logic w_adv;
    logic w_accept;
    logic r_v1, r_v2, r_v3;

    assign w_adv    = !o_valid || i_ready;
    assign o_ready  = w_adv && i_rst_n;
    assign w_accept = i_valid && w_adv;

    // ------------------------------------------------------------------
    // Stage 1 (at accept): error, clamped integrator, derivative on the
    // measurement and the window check. The integrator and previous
    // angle are loop state and update on every accepted transaction.
    // ------------------------------------------------------------------
    logic signed [INTEG_W-1:0] r_integrator;
    logic signed [ANGLE_W-1:0] r_last_angle;

    logic signed [ERR_W-1:0]   w_err;
    logic signed [ERR_W-1:0]   w_deriv;
    logic signed [SUM_W-1:0]   w_sum;
    logic signed [INTEG_W-1:0] n_integrator;
    logic signed [ERR_W-1:0]   w_angle_x;
    logic signed [ERR_W-1:0]   w_lim_pos;
    logic signed [ERR_W-1:0]   w_lim_neg;
    logic                      w_off;

    always_comb begin
        w_angle_x = ERR_W'(i_tilt_angle);
        w_err     = ERR_W'(r_target) - w_angle_x;
        w_deriv   = ERR_W'(r_last_angle) - w_angle_x;
        w_sum     = SUM_W'(r_integrator) + SUM_W'(w_err);
        // crossed bounds: sums above the upper bound take it, others the lower
        priority if (w_sum > SUM_W'(r_integ_max)) begin
            n_integrator = r_integ_max;
        end else if (w_sum < SUM_W'(r_integ_min)) begin
            n_integrator = r_integ_min;
        end else begin
            n_integrator = w_sum[INTEG_W-1:0];
        end
        w_lim_pos = $signed({2'b00, r_tilt_limit});
        w_lim_neg = -w_lim_pos;
        w_off     = (w_angle_x > w_lim_pos) || (w_angle_x < w_lim_neg)
                    || (i_tilt_angle == '0);
    end

    logic signed [ERR_W-1:0]   r1_err;
    logic signed [ERR_W-1:0]   r1_deriv;
    logic signed [INTEG_W-1:0] r1_integ;
    logic                      r1_off;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integrator <= '0;
            r_last_angle <= '0;
        end else if (w_accept) begin
            r_integrator <= n_integrator;
            r_last_angle <= i_tilt_angle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_err   <= w_err;
            r1_deriv <= w_deriv;
            r1_integ <= n_integrator;
            r1_off   <= w_off;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: the three gain products, each into its own register.
    // ------------------------------------------------------------------
    logic signed [PROD_E_W-1:0] r2_p_term;
    logic signed [PROD_I_W-1:0] r2_i_term;
    logic signed [PROD_E_W-1:0] r2_d_term;
    logic                       r2_off;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_p_term <= $signed({1'b0, r_p_gain}) * r1_err;
            r2_i_term <= $signed({1'b0, r_i_gain}) * r1_integ;
            r2_d_term <= $signed({1'b0, r_d_gain}) * r1_deriv;
            r2_off    <= r1_off;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: Q16 drive sum.
    // ------------------------------------------------------------------
    logic signed [DRIVE_W-1:0] r3_drive;
    logic                      r3_off;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_drive <= DRIVE_W'(r2_p_term) + DRIVE_W'(r2_i_term) + DRIVE_W'(r2_d_term);
            r3_off   <= r2_off;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: magnitude truncated toward zero, saturation at the duty
    // limit, and the held duty/direction that the output presents.
    // ------------------------------------------------------------------
    logic [DRIVE_W-1:0] w_abs;
    logic [MAG_W-1:0]   w_mag;
    logic [DUTY_W-1:0]  w_duty_sat;

    always_comb begin
        w_abs      = r3_drive[DRIVE_W-1] ? (~r3_drive + 1'b1) : r3_drive;
        w_mag      = w_abs[DRIVE_W-1:FRAC_W];
        w_duty_sat = (w_mag > MAG_W'(r_duty_limit)) ? r_duty_limit : w_mag[DUTY_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1           <= 1'b0;
            r_v2           <= 1'b0;
            r_v3           <= 1'b0;
            o_valid        <= 1'b0;
            o_motor_enable <= 1'b0;
            o_reverse      <= 1'b0;
            o_duty         <= '0;
        end else if (w_adv) begin
            r_v1    <= i_valid;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            o_valid <= r_v3;
            if (r_v3) begin
                priority if (r3_off) begin
                    // out of window or level: bridge off, duty drops to zero
                    o_motor_enable <= 1'b0;
                    o_duty         <= '0;
                end else if (r3_drive != '0) begin
                    o_motor_enable <= 1'b1;
                    o_duty         <= w_duty_sat;
                    o_reverse      <= r3_drive[DRIVE_W-1];
                end else begin
                    // zero drive: bridge off, hold last duty and direction
                    o_motor_enable <= 1'b0;
                end
            end
        end
    end

endmodule
`default_nettype wire
